@@ rtl/stxlfe_pkg.sv @@
// Package for the STX length frame extractor.
// Holds protocol constants, register indexes and the controller/datapath
// command and status bundles. Depends on nothing.
package stxlfe_pkg;

  // Default sizes of the accumulation buffer and the largest frame.
  localparam int DEF_BUFFER_BYTES    = 128;
  localparam int DEF_MAX_FRAME_BYTES = 64;

  // Most result beats produced for one received byte.
  localparam int MAX_RESULTS = 64;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  // Frame length is a 16-bit count plus a small constant.
  localparam int FLEN_W = 17;

  // Protocol bytes and length adjustments.
  localparam logic [7:0] STX_BYTE    = 8'h02;
  localparam logic [7:0] MARK_EXT_A  = 8'h81;
  localparam logic [7:0] MARK_EXT_B  = 8'hFD;
  localparam int         EXT_LEN_ADD = 4;
  localparam int         STD_LEN_ADD = 5;
  localparam int         HDR_MIN     = 3;
  localparam int         HDR_EXT_MIN = 4;

  // Heartbeat pattern limits.
  localparam logic [3:0] PING_MAX       = 4'd8;
  localparam logic [3:0] PING_LEN_RESET = 4'd8;

  // Register indexes, selected by address bit 3.
  localparam logic REG_PING_PATTERN = 1'b0;
  localparam logic REG_PING_LENGTH  = 1'b1;

  // Result kinds.
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_PONG  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;   // append the accepted byte
    logic off_clr;     // offset to zero
    logic off_one;     // offset to one
    logic off_inc;     // offset plus one
    logic drop_one;    // remove one byte at the head
    logic drop_ping;   // remove the heartbeat pattern
    logic drop_frame;  // remove the whole frame
    logic cap_mark;    // capture marker byte
    logic cap_b2;      // capture short length byte
    logic cap_b3;      // capture high length byte
    logic n_clr;       // clear the result count
    logic load_pong;   // load a pong beat
    logic load_frame;  // load a frame byte beat
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic ping_try;
    logic cnt_lt3;
    logic cnt_lt4;
    logic is_stx;
    logic ping_match;
    logic ping_last;
    logic mark_ext;
    logic flen_big;
    logic flen_gt_cnt;
    logic slots_over;
    logic slots_full;
    logic frame_last;
    logic out_busy;
  } status_t;

endpackage

@@ rtl/stxlfe_controller.sv @@
// Sequencer of the frame extractor: scans, matches heartbeats, parses headers
// and replays frames one buffer read at a time. Uses stxlfe_pkg.
module stxlfe_controller
  import stxlfe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CHK = 4'd2;
  localparam logic [3:0] S_PING_RD  = 4'd3;
  localparam logic [3:0] S_PING_CHK = 4'd4;
  localparam logic [3:0] S_MARK_RD  = 4'd5;
  localparam logic [3:0] S_MARK_CHK = 4'd6;
  localparam logic [3:0] S_B2_RD    = 4'd7;
  localparam logic [3:0] S_B2_CHK   = 4'd8;
  localparam logic [3:0] S_B3_RD    = 4'd9;
  localparam logic [3:0] S_B3_CHK   = 4'd10;
  localparam logic [3:0] S_LEN_CHK  = 4'd11;
  localparam logic [3:0] S_EMIT_RD  = 4'd12;
  localparam logic [3:0] S_EMIT_OUT = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_byte = 1'b1;
          cmd.n_clr     = 1'b1;
          cmd.off_clr   = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_next = st.cnt_zero ? S_IDLE : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (!st.is_stx) begin
          cmd.drop_one = 1'b1;
          state_next   = S_SCAN_RD;
        end else if (st.ping_try) begin
          state_next = S_PING_RD;
        end else if (st.cnt_lt3) begin
          state_next = S_IDLE;
        end else begin
          cmd.off_one = 1'b1;
          state_next  = S_MARK_RD;
        end
      end
      S_PING_RD: begin
        state_next = S_PING_CHK;
      end
      S_PING_CHK: begin
        if (!st.ping_match) begin
          // Not a heartbeat: parse the header instead.
          if (st.cnt_lt3) begin
            state_next = S_IDLE;
          end else begin
            cmd.off_one = 1'b1;
            state_next  = S_MARK_RD;
          end
        end else if (!st.ping_last) begin
          cmd.off_inc = 1'b1;
          state_next  = S_PING_RD;
        end else if (st.slots_full) begin
          state_next = S_IDLE;
        end else if (!st.out_busy) begin
          cmd.load_pong = 1'b1;
          cmd.drop_ping = 1'b1;
          cmd.off_clr   = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_MARK_RD: begin
        state_next = S_MARK_CHK;
      end
      S_MARK_CHK: begin
        cmd.cap_mark = 1'b1;
        cmd.off_inc  = 1'b1;
        state_next   = S_B2_RD;
      end
      S_B2_RD: begin
        state_next = S_B2_CHK;
      end
      S_B2_CHK: begin
        cmd.cap_b2 = 1'b1;
        if (!st.mark_ext) begin
          state_next = S_LEN_CHK;
        end else if (st.cnt_lt4) begin
          state_next = S_IDLE;
        end else begin
          cmd.off_inc = 1'b1;
          state_next  = S_B3_RD;
        end
      end
      S_B3_RD: begin
        state_next = S_B3_CHK;
      end
      S_B3_CHK: begin
        cmd.cap_b3 = 1'b1;
        state_next = S_LEN_CHK;
      end
      S_LEN_CHK: begin
        if (st.flen_big) begin
          // Implausible length: drop this STX and resync.
          cmd.drop_one = 1'b1;
          cmd.off_clr  = 1'b1;
          state_next   = S_SCAN_RD;
        end else if (st.flen_gt_cnt || st.slots_over) begin
          state_next = S_IDLE;
        end else begin
          cmd.off_clr = 1'b1;
          state_next  = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (!st.out_busy) begin
          cmd.load_frame = 1'b1;
          if (st.frame_last) begin
            cmd.drop_frame = 1'b1;
            cmd.off_clr    = 1'b1;
            state_next     = S_SCAN_RD;
          end else begin
            cmd.off_inc = 1'b1;
            state_next  = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/stxlfe_datapath.sv @@
// Datapath of the frame extractor: circular byte buffer, head and count,
// offset, header registers, result count, output beat and registers.
// Uses stxlfe_pkg.
module stxlfe_datapath
  import stxlfe_pkg::*;
#(
  parameter int BUFFER_BYTES    = DEF_BUFFER_BYTES,
  parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     st,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata
);

  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam int PTR_W = $clog2(BUFFER_BYTES);
  localparam int OFF_W = (MAX_FRAME_BYTES > 8) ? $clog2(MAX_FRAME_BYTES) : 3;
  localparam int SUM_W = ((CNT_W > OFF_W) ? CNT_W : OFF_W) + 1;

  logic [7:0]        mem [BUFFER_BYTES];
  logic [7:0]        rdata;
  logic [PTR_W-1:0]  head;
  logic [CNT_W-1:0]  count;
  logic [OFF_W-1:0]  off;
  logic [7:0]        mark;
  logic [7:0]        b2;
  logic [FLEN_W-1:0] flen;
  logic [RES_W-1:0]  n;
  logic [63:0]       ping_pattern;
  logic [3:0]        ping_length;

  logic [3:0]        plen;
  logic              buf_full;
  logic [SUM_W-1:0]  wr_sum;
  logic [SUM_W-1:0]  rd_sum;
  logic [SUM_W-1:0]  drop_sum;
  logic [CNT_W-1:0]  drop_k;
  logic [PTR_W-1:0]  wr_addr;
  logic [PTR_W-1:0]  rd_addr;
  logic [63:0]       ping_shift;

  // Effective heartbeat length, capped at eight bytes.
  assign plen     = (ping_length > PING_MAX) ? PING_MAX : ping_length;
  assign buf_full = (count >= CNT_W'(BUFFER_BYTES));

  // Buffer addresses wrap around the buffer size.
  always_comb begin
    wr_sum = SUM_W'(head) + SUM_W'(count);
    if (wr_sum >= SUM_W'(BUFFER_BYTES)) begin
      wr_sum = wr_sum - SUM_W'(BUFFER_BYTES);
    end
    wr_addr = buf_full ? '0 : wr_sum[PTR_W-1:0];
    rd_sum  = SUM_W'(head) + SUM_W'(off);
    if (rd_sum >= SUM_W'(BUFFER_BYTES)) begin
      rd_sum = rd_sum - SUM_W'(BUFFER_BYTES);
    end
    rd_addr = rd_sum[PTR_W-1:0];
  end

  // Number of bytes removed from the head.
  always_comb begin
    if (cmd.drop_one) begin
      drop_k = CNT_W'(1);
    end else if (cmd.drop_ping) begin
      drop_k = CNT_W'(plen);
    end else begin
      drop_k = flen[CNT_W-1:0];
    end
    drop_sum = SUM_W'(head) + SUM_W'(drop_k);
    if (drop_sum >= SUM_W'(BUFFER_BYTES)) begin
      drop_sum = drop_sum - SUM_W'(BUFFER_BYTES);
    end
  end

  // Byte memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      mem[wr_addr] <= rx_byte;
    end
    rdata <= mem[rd_addr];
  end

  // Head and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.take_byte) begin
      if (buf_full) begin
        head  <= '0;
        count <= CNT_W'(1);
      end else begin
        count <= count + CNT_W'(1);
      end
    end else if (cmd.drop_one || cmd.drop_ping || cmd.drop_frame) begin
      head  <= drop_sum[PTR_W-1:0];
      count <= count - drop_k;
    end
  end

  // Read offset and result count.
  always_ff @(posedge clk) begin
    if (rst) begin
      off <= '0;
      n   <= '0;
    end else begin
      if (cmd.off_clr) begin
        off <= '0;
      end else if (cmd.off_one) begin
        off <= OFF_W'(1);
      end else if (cmd.off_inc) begin
        off <= off + OFF_W'(1);
      end
      if (cmd.n_clr) begin
        n <= '0;
      end else if (cmd.load_pong || cmd.load_frame) begin
        n <= n + RES_W'(1);
      end
    end
  end

  // Header capture and frame length.
  always_ff @(posedge clk) begin
    if (cmd.cap_mark) begin
      mark <= rdata;
    end
    if (cmd.cap_b2) begin
      b2   <= rdata;
      flen <= FLEN_W'(rdata) + FLEN_W'(STD_LEN_ADD);
    end
    if (cmd.cap_b3) begin
      flen <= FLEN_W'({rdata, b2}) + FLEN_W'(EXT_LEN_ADD);
    end
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_pong || cmd.load_frame) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pong) begin
      out_kind <= KIND_PONG;
      out_byte <= '0;
      out_last <= 1'b1;
    end else if (cmd.load_frame) begin
      out_kind <= KIND_FRAME;
      out_byte <= rdata;
      out_last <= st.frame_last;
    end
  end

  // Configuration registers; address bit 3 selects the register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ping_pattern <= '0;
      ping_length  <= PING_LEN_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[3] == REG_PING_PATTERN) begin
        ping_pattern <= pwdata;
      end else begin
        ping_length <= pwdata[3:0];
      end
    end
  end

  assign prdata = (paddr[3] == REG_PING_LENGTH) ? {60'd0, ping_length} : ping_pattern;

  // Status flags.
  assign ping_shift = ping_pattern >> {off[2:0], 3'b000};

  always_comb begin
    st.cnt_zero    = (count == '0);
    st.ping_try    = (plen != '0) && (count >= CNT_W'(plen));
    st.cnt_lt3     = (count < CNT_W'(HDR_MIN));
    st.cnt_lt4     = (count < CNT_W'(HDR_EXT_MIN));
    st.is_stx      = (rdata == STX_BYTE);
    st.ping_match  = (rdata == ping_shift[7:0]);
    st.ping_last   = ((4'({1'b0, off[2:0]}) + 4'd1) == plen);
    st.mark_ext    = (mark == MARK_EXT_A) || (mark == MARK_EXT_B);
    st.flen_big    = (flen > FLEN_W'(MAX_FRAME_BYTES));
    st.flen_gt_cnt = (flen > FLEN_W'(count));
    st.slots_over  = ((FLEN_W'(n) + flen) > FLEN_W'(MAX_RESULTS));
    st.slots_full  = (n >= RES_W'(MAX_RESULTS));
    st.frame_last  = ((FLEN_W'(off) + FLEN_W'(1)) == flen);
    st.out_busy    = out_valid && !out_ready;
  end

endmodule

@@ rtl/stx_length_frame_extractor_top.sv @@
// Each taken byte starts a pass: the sequencer scans for STX, compares a heartbeat pattern
// byte by byte, parses the header and, once the frame is complete, replays it one buffer
// read per beat. No new byte is taken until the pass ends and the sequencer is idle;
// while a frame is collected, each byte reparses the header.
// The sequencer reads the buffer one registered read at a time; a stalled beat stops it.
// Reset (synchronous, active high) empties the buffer, clears the output beat and
// sets the heartbeat pattern to zero and its length to eight.
module stx_length_frame_extractor_top
  import stxlfe_pkg::*;
#(
  parameter int BUFFER_BYTES    = DEF_BUFFER_BYTES,
  parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cmd_t    cmd;
  status_t st;

  assign pready = 1'b1;

  // Sequencer.
  stxlfe_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Buffer, registers and output beat.
  stxlfe_datapath #(
    .BUFFER_BYTES    (BUFFER_BYTES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
  );

endmodule

@@ rtl/stxlfe_checker.sv @@
// Port-level checks of the frame extractor, bound to the top level.
// Depends only on the top level's ports.
module stxlfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // Reset leaves no result beat pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat pending after reset");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_kind)
      && $stable(out_last))
    else $error("stalled result beat changed");

  // A pong beat is a single last beat with a zero byte.
  a_pong_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind |-> out_last && (out_byte == 8'd0))
    else $error("malformed pong beat");

  // After a byte is taken the block is busy scanning and is not ready in the cycle after.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a taken beat");

endmodule

bind stx_length_frame_extractor_top stxlfe_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_kind  (out_kind),
  .out_byte  (out_byte),
  .out_last  (out_last)
);

@@ tb/stx_length_frame_extractor_top_tb.sv @@
// Testbench for the STX length frame extractor top level.
// Drives received bytes and APB register writes, predicts frames and pongs,
// and checks every output beat. Depends on stxlfe_pkg and the top-level RTL.
module stx_length_frame_extractor_top_tb;
  import stxlfe_pkg::*;

  localparam int BUF_BYTES = 128;
  localparam int MAX_FRAME = 64;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  stx_length_frame_extractor_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_byte(out_byte), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow state of the extractor.
  logic [7:0]  shadow_buf[BUF_BYTES];
  int unsigned shadow_cnt;
  logic [63:0] hb_pattern;
  logic [3:0]  hb_len;

  logic [7:0]  byte_queue[$];
  beat_t       expected_beats[$];
  int          error_count;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned beats_seen;
  int unsigned pongs_seen;
  bit          rx_gaps_on;
  bit          tx_gaps_on;
  bit          hold_output;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Remove k bytes from the head of the shadow buffer.
  function automatic void shift_out(int unsigned k);
    if (k >= shadow_cnt) begin
      shadow_cnt = 0;
    end else begin
      for (int unsigned j = 0; j < shadow_cnt - k; j++) shadow_buf[j] = shadow_buf[j + k];
      shadow_cnt = shadow_cnt - k;
    end
  endfunction

  // Append one byte and queue every beat that it releases.
  function automatic void extract_frames(logic [7:0] b);
    int unsigned n;
    int unsigned plen;
    int unsigned flen;
    int unsigned s;
    bit          hit;
    beat_t       bt;
    n = 0;
    if (shadow_cnt >= BUF_BYTES) shadow_cnt = 0;
    shadow_buf[shadow_cnt] = b;
    shadow_cnt++;
    while (shadow_cnt > 0) begin
      if (shadow_buf[0] != STX_BYTE) begin
        s = 0;
        while (s < shadow_cnt && shadow_buf[s] != STX_BYTE) s++;
        shift_out(s);
        if (shadow_cnt == 0) break;
      end
      plen = (hb_len > PING_MAX) ? 8 : hb_len;
      if (plen != 0 && shadow_cnt >= plen) begin
        hit = 1'b1;
        for (int unsigned i = 0; i < plen; i++)
          if (shadow_buf[i] != hb_pattern[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          if (n >= MAX_RESULTS) break;
          bt.kind = KIND_PONG;
          bt.data = 8'h00;
          bt.last = 1'b1;
          expected_beats.push_back(bt);
          n++;
          shift_out(plen);
          continue;
        end
      end
      if (shadow_cnt < HDR_MIN) break;
      if (shadow_buf[1] == MARK_EXT_A || shadow_buf[1] == MARK_EXT_B) begin
        if (shadow_cnt < HDR_EXT_MIN) break;
        flen = {shadow_buf[3], shadow_buf[2]} + EXT_LEN_ADD;
      end else begin
        flen = shadow_buf[2] + STD_LEN_ADD;
      end
      if (flen > MAX_FRAME) begin
        shift_out(1);
        continue;
      end
      if (flen > shadow_cnt) break;
      if (n + flen > MAX_RESULTS) break;
      for (int unsigned i = 0; i < flen; i++) begin
        bt.kind = KIND_FRAME;
        bt.data = shadow_buf[i];
        bt.last = (i + 1 == flen);
        expected_beats.push_back(bt);
        n++;
      end
      shift_out(flen);
    end
  endfunction

  // Build frames of various shapes into the byte queue.
  task automatic queue_frame(bit ext, int unsigned body);
    int unsigned flen;
    if (ext) begin
      flen = body + 4;
      byte_queue.push_back(STX_BYTE);
      byte_queue.push_back($urandom_range(0, 1) ? MARK_EXT_A : MARK_EXT_B);
      byte_queue.push_back(8'(flen - 4));
      byte_queue.push_back(8'h00);
      for (int unsigned i = 4; i < flen; i++) byte_queue.push_back(8'($urandom));
    end else begin
      flen = body + 5;
      byte_queue.push_back(STX_BYTE);
      byte_queue.push_back(8'($urandom));
      byte_queue.push_back(8'(body));
      for (int unsigned i = 3; i < flen; i++) byte_queue.push_back(8'($urandom));
    end
  endtask

  // The pattern holds eight bytes, so longer lengths send all eight.
  task automatic queue_ping();
    int unsigned plen;
    plen = (hb_len > PING_MAX) ? 8 : hb_len;
    for (int unsigned i = 0; i < plen; i++) byte_queue.push_back(hb_pattern[8*i +: 8]);
  endtask

  task automatic apb_write(logic [3:0] addr, logic [63:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr[3] == REG_PING_LENGTH) hb_len = data[3:0];
    else hb_pattern = data;
  endtask

  // Let the queued bytes drain and the block go idle.
  task automatic wait_idle();
    while (byte_queue.size() != 0 || in_valid || expected_beats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Random phase: mostly well-formed frames and pings, some noise.
  task automatic random_phase(int unsigned count);
    int unsigned r;
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) queue_frame(1'b0, $urandom_range(0, 12));
      else if (r < 55) queue_frame(1'b1, $urandom_range(0, 14));
      else if (r < 60) queue_frame(1'b0, $urandom_range(0, 59));
      else if (r < 72) queue_ping();
      else if (r < 80) begin
        byte_queue.push_back(STX_BYTE);
        byte_queue.push_back(8'($urandom));
        byte_queue.push_back(8'($urandom_range(60, 255)));
      end else byte_queue.push_back(8'($urandom));
    end
  endtask

  // Sender: offers queued bytes, idling at random.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte <= 8'h00;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        extract_frames(rx_byte);
        bytes_sent++;
      end
      if (byte_queue.size() != 0 && !(rx_gaps_on && $urandom_range(0, 99) < 13)) begin
        in_valid <= 1'b1;
        rx_byte <= byte_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each accepted beat against the oldest prediction.
  always @(posedge clk) begin
    beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_seen++;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat kind=%0d byte=%02h last=%0d",
                   $time, out_kind, out_byte, out_last);
          error_count++;
        end else begin
          want = expected_beats.pop_front();
          if (want.kind == KIND_PONG) pongs_seen++;
          if (out_kind !== want.kind) begin
            $display("%0t: out_kind expected %0d actual %0d", $time, want.kind, out_kind);
            error_count++;
          end
          if (out_byte !== want.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
            error_count++;
          end
          if (out_last !== want.last) begin
            $display("%0t: out_last expected %0d actual %0d", $time, want.last, out_last);
            error_count++;
          end
        end
      end
      out_ready <= !hold_output && !(tx_gaps_on && $urandom_range(0, 99) < 13);
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("stx_length_frame_extractor_top_tb: errors");
      $finish;
    end
  end

  // Long receiver hold-off so that the block backs up into its input.
  initial begin
    hold_output = 1'b0;
    wait (bytes_sent > 60);
    hold_output = 1'b1;
    repeat (600) @(posedge clk);
    hold_output = 1'b0;
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; rx_byte = 8'h00; out_ready = 1'b0;
    shadow_cnt = 0; hb_pattern = '0; hb_len = PING_LEN_RESET;
    error_count = 0; cycle_count = 0; bytes_sent = 0; beats_seen = 0; pongs_seen = 0;
    rx_gaps_on = 1'b0; tx_gaps_on = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part with reset registers: a zero pattern of eight bytes.
    byte_queue.push_back(8'hFF);
    byte_queue.push_back(8'h00);
    queue_frame(1'b0, 0);
    queue_frame(1'b1, 0);
    byte_queue.push_back(STX_BYTE);
    byte_queue.push_back(8'h10);
    byte_queue.push_back(8'd200);
    byte_queue.push_back(STX_BYTE);
    byte_queue.push_back(MARK_EXT_A);
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'h01);
    queue_frame(1'b0, 59);
    queue_ping();
    wait_idle();

    // Single-byte heartbeat that is the STX itself, then the widest pattern.
    apb_write(4'h0, 64'hFFFF_FFFF_FFFF_FF02);
    apb_write(4'h8, 64'd1);
    byte_queue.push_back(STX_BYTE);
    byte_queue.push_back(8'h55);
    wait_idle();
    apb_write(4'h0, 64'hAA55_F00F_C33C_7E02);
    apb_write(4'h8, 64'd8);
    rx_gaps_on = 1'b1;
    tx_gaps_on = 1'b1;
    random_phase(6);
    wait_idle();

    // Heartbeat disabled, a run of noise behind an out-of-range length.
    apb_write(4'h8, 64'd0);
    for (int i = 0; i < 20; i++) byte_queue.push_back(i == 0 ? STX_BYTE : 8'h7F);
    random_phase(4);
    wait_idle();
    apb_write(4'h8, 64'd15);
    random_phase(3);
    wait_idle();

    // Short pattern, no gaps for a stretch then gaps again.
    apb_write(4'h0, 64'h0000_0000_0000_9902);
    apb_write(4'h8, 64'd2);
    rx_gaps_on = 1'b0;
    tx_gaps_on = 1'b0;
    random_phase(3);
    wait_idle();
    rx_gaps_on = 1'b1;
    tx_gaps_on = 1'b1;
    apb_write(4'h0, 64'h0000_0000_0033_2202);
    apb_write(4'h8, 64'd3);
    random_phase(5);
    wait_idle();

    $display("Sent %0d bytes and checked %0d output beats, %0d of them pongs.",
             bytes_sent, beats_seen, pongs_seen);
    if (error_count == 0) begin
      $display("stx_length_frame_extractor_top_tb: clean");
    end else begin
      $display("stx_length_frame_extractor_top_tb: errors");
    end
    $finish;
  end

endmodule
